>>> hdl/tvs_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tvs_pkg
// Shared types and constants of the timed valve sequencer.
// -----------------------------------------------------------------------------
package tvs_pkg;

  localparam int MaxEntries = 16;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int PinW       = 8;
  localparam int TickW      = 16;
  localparam int CmdW       = 2;
  localparam int CfgIdxW    = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_ON   = 2'd1,
    PEND_OFF  = 2'd2
  } pend_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PUMP_PRESENT = 2'd0,
    CFG_PUMP_ON_DLY  = 2'd1,
    CFG_PUMP_OFF_DLY = 2'd2
  } cfg_reg_e;

  // one table entry as stored in RAM
  typedef struct packed {
    logic [PinW-1:0]  pin;
    logic [TickW-1:0] dur;
  } entry_t;

  // status carried from the update stage to the output register
  typedef struct packed {
    logic            running;
    logic            pump;
    logic [CntW-1:0] count;
  } status_t;

endpackage
`default_nettype wire

>>> hdl/tvs_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tvs_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module tvs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];  // old data on same-address write
  end

endmodule
`default_nettype wire

>>> hdl/timed_valve_sequencer_unit.sv
`default_nettype none
// -----------------------------------------------------------------------------
// timed_valve_sequencer_unit
// Opens a table of valves one after another for per-entry tick counts and
// switches an optional pump through one on/off delay timer.
// -----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_ready_o   cmd_i, valve_pin_i, open_ticks_i
//  out      source     out_valid_o / out_ready_i open_pin_o, valve_open_o,
//                                                pump_running_o, busy_res_o,
//                                                entries_loaded_o
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  One transaction per cycle sustained while the output is not stalled. All
//  control state updates in the cycle a command is taken; the result is held
//  in the update stage, then in the output register, which drives out_valid_o.
//  The entry RAM is read every cycle at the next current entry, so its data is
//  ready for the following command; a same-entry append is forwarded.
//  Reset clears all control state; the table needs no clearing pass.
//  A stalled output holds one result in the update stage and one in the
//  output register; in_ready_o drops only when both are full.
// -----------------------------------------------------------------------------
module timed_valve_sequencer_unit
  import tvs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // command channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [CmdW-1:0]    cmd_i,
  input  wire logic [PinW-1:0]    valve_pin_i,
  input  wire logic [TickW-1:0]   open_ticks_i,
  // status channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [PinW-1:0]    open_pin_o,
  output logic                    valve_open_o,
  output logic                    pump_running_o,
  output logic                    busy_res_o,
  output logic      [CntW-1:0]    entries_loaded_o,
  // configuration channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [TickW-1:0]   cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic             present_q;
  logic [TickW-1:0] on_dly_q;
  logic [TickW-1:0] off_dly_q;
  logic             cfg_acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      on_dly_q  <= '0;
      off_dly_q <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PUMP_PRESENT: present_q <= cfg_data_i[0];
        CFG_PUMP_ON_DLY:  on_dly_q  <= cfg_data_i;
        CFG_PUMP_OFF_DLY: off_dly_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]  count_q,   count_d;
  logic [IdxW-1:0]  cur_q,     cur_d;
  logic [TickW-1:0] elapsed_q, elapsed_d;
  logic             running_q, running_d;
  logic [TickW-1:0] timer_q,   timer_d;
  pend_e            pend_q,    pend_d;
  logic             pump_q,    pump_d;

  logic             in_acc;
  logic             out_adv;
  logic             s1_vld_q;
  status_t          s1_q;
  logic             out_vld_q;
  status_t          out_q;
  logic [PinW-1:0]  pin_q;

  // entry RAM and same-entry forwarding
  logic             wr_en;
  entry_t           wr_data;
  entry_t           ram_rdata;
  entry_t           fwd_data_q;
  logic             fwd_vld_q;
  entry_t           cur_ent;

  assign cur_ent = fwd_vld_q ? fwd_data_q : ram_rdata;
  assign wr_data = '{pin: valve_pin_i, dur: open_ticks_i};

  tvs_ram #(
    .Width ($bits(entry_t)),
    .Depth (MaxEntries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (wr_data),
    .raddr_i (cur_d),
    .rdata_o (ram_rdata)
  );

  assign in_acc = in_valid_i & in_ready_o;

  // command decode and state update
  always_comb begin
    logic [TickW-1:0] tmr;
    logic [TickW-1:0] el;
    logic [CntW-1:0]  nxt;

    tmr       = timer_q;
    el        = elapsed_q;
    nxt       = '0;
    count_d   = count_q;
    cur_d     = cur_q;
    elapsed_d = elapsed_q;
    running_d = running_q;
    timer_d   = timer_q;
    pend_d    = pend_q;
    pump_d    = pump_q;
    wr_en     = 1'b0;

    if (in_acc) begin
      unique case (cmd_e'(cmd_i))
        CMD_TICK: begin
          // pump timer first
          if (pend_q != PEND_NONE) begin
            tmr     = (timer_q != '0) ? timer_q - TickW'(1) : timer_q;
            timer_d = tmr;
            if (tmr == '0) begin
              pump_d = (pend_q == PEND_ON);
              pend_d = PEND_NONE;
            end
          end
          // then the open valve
          if (running_q) begin
            el = (elapsed_q != '1) ? elapsed_q + TickW'(1) : elapsed_q;
            if (el >= cur_ent.dur) begin
              el  = '0;
              nxt = CntW'(cur_q) + CntW'(1);
              if (nxt >= count_q) begin
                cur_d     = '0;
                running_d = 1'b0;
                if (present_q) begin
                  timer_d = (off_dly_q == '0) ? TickW'(1) : off_dly_q;
                  pend_d  = PEND_OFF;
                end
              end else begin
                cur_d = nxt[IdxW-1:0];
              end
            end
            elapsed_d = el;
          end
        end
        CMD_START: begin
          if (!running_q && count_q != '0) begin
            running_d = 1'b1;
            cur_d     = '0;
            elapsed_d = '0;
            if (present_q) begin
              timer_d = (on_dly_q == '0) ? TickW'(1) : on_dly_q;
              pend_d  = PEND_ON;
            end
          end
        end
        CMD_APPEND: begin
          if (count_q < CntW'(MaxEntries)) begin
            wr_en   = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        CMD_NOP: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cur_q     <= '0;
      elapsed_q <= '0;
      running_q <= 1'b0;
      timer_q   <= '0;
      pend_q    <= PEND_NONE;
      pump_q    <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      cur_q     <= cur_d;
      elapsed_q <= elapsed_d;
      running_q <= running_d;
      timer_q   <= timer_d;
      pend_q    <= pend_d;
      pump_q    <= pump_d;
      // RAM returns old data when written at the address being read
      fwd_vld_q <= wr_en && (count_q[IdxW-1:0] == cur_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_data_q <= wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Result pipeline: update stage then output register. The pin is looked up
  // when the result moves on, once the RAM shows the new current entry.
  // ---------------------------------------------------------------------------
  assign out_adv    = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (out_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (out_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= '{running: running_d, pump: pump_d, count: count_d};
    end
    if (out_adv) begin
      out_q <= s1_q;
      pin_q <= s1_q.running ? cur_ent.pin : '0;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign open_pin_o       = pin_q;
  assign valve_open_o     = out_q.running;
  assign busy_res_o       = out_q.running;
  assign pump_running_o   = out_q.pump;
  assign entries_loaded_o = out_q.count;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_run_needs_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (CntW'(cur_q) < count_q))
    else $error("running with current entry outside the table");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("entry count beyond table size");

  a_pending_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != PEND_NONE) |-> (timer_q != '0))
    else $error("pump delay pending with an expired timer");

  a_idle_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (cur_q == '0) && (elapsed_q == '0 || $past(running_q)
                                      || elapsed_q == $past(elapsed_q)))
    else $error("current entry not rewound when idle");

  a_out_hold_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && !out_ready_i) |-> !in_ready_o)
    else $error("command taken with both result stages full");

endmodule
`default_nettype wire
